[rtl/median_filter_3x3_rgb_assert.svh]
// Assertion macros for the median filter checker.
`ifndef MEDIAN_FILTER_3X3_RGB_ASSERT_SVH
`define MEDIAN_FILTER_3X3_RGB_ASSERT_SVH

`define MF3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`define MF3_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

[rtl/mf3_pkg.sv]
package mf3_pkg;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int PIX_W = 32;
  localparam int CFGW_W = 12;
  localparam int CFGH_W = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFGW_W-1:0] WIDTH_RESET = 12'd640;
  localparam logic [CFGH_W-1:0] HEIGHT_RESET = 13'd480;
  localparam int FIFO_DEPTH = 8;
  localparam int TAPS = 9;

  typedef enum logic [CFG_IDX_W-1:0] {CFG_WIDTH = 1'b0, CFG_HEIGHT = 1'b1} cfg_idx_t;
  typedef enum logic [0:0] {OP_PIXEL = 1'b0, OP_DRAIN = 1'b1} op_t;

  typedef struct packed {
    logic interior;
    logic last;
  } mf3_tag_t;

  typedef logic [7:0] chan_t;

  function automatic chan_t max2(chan_t a, chan_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic chan_t min2(chan_t a, chan_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic chan_t med3(chan_t a, chan_t b, chan_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // {hi, mid, lo}
  function automatic logic [23:0] sort3(chan_t a, chan_t b, chan_t c);
    return {max2(max2(a, b), c), med3(a, b, c), min2(min2(a, b), c)};
  endfunction
endpackage

[rtl/mf3_if.sv]
interface mf3_in_if;
  import mf3_pkg::*;
  logic valid;
  logic ready;
  logic op;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, output op, output pixel_in, input ready);
  modport sink (input valid, input op, input pixel_in, output ready);
endinterface

interface mf3_out_if;
  import mf3_pkg::*;
  logic valid;
  logic ready;
  logic [PIX_W-1:0] pixel_out;
  logic frame_last;
  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface mf3_cfg_if;
  import mf3_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/mf3_line_mem.sv]
module mf3_line_mem #(
  parameter int DEPTH = mf3_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [mf3_pkg::PIX_W-1:0]  wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [mf3_pkg::PIX_W-1:0]  rdata
);
  import mf3_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/mf3_median.sv]
module mf3_median (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  mf3_pkg::mf3_tag_t                      in_tag,
  input  logic [mf3_pkg::TAPS-1:0][mf3_pkg::PIX_W-1:0] win,
  output logic                                   s1_busy,
  output logic                                   out_valid,
  output logic [mf3_pkg::PIX_W-1:0]              out_pixel,
  output logic                                   out_last
);
  import mf3_pkg::*;

  logic [2:0][2:0][23:0] s1_sorted;
  logic [PIX_W-1:0] s1_center;
  mf3_tag_t s1_tag;
  logic s1_valid;
  logic [2:0][2:0][23:0] sorted;
  logic [2:0][7:0] med;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        sorted[ch][r] = sort3(win[r*3][ch*8 +: 8], win[r*3+1][ch*8 +: 8],
                              win[r*3+2][ch*8 +: 8]);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      med[ch] = med3(max2(max2(s1_sorted[ch][0][7:0], s1_sorted[ch][1][7:0]),
                          s1_sorted[ch][2][7:0]),
                     med3(s1_sorted[ch][0][15:8], s1_sorted[ch][1][15:8],
                          s1_sorted[ch][2][15:8]),
                     min2(min2(s1_sorted[ch][0][23:16], s1_sorted[ch][1][23:16]),
                          s1_sorted[ch][2][23:16]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      out_valid <= s1_valid;
    end
    s1_sorted <= sorted;
    s1_center <= win[4];
    s1_tag <= in_tag;
    out_pixel <= s1_tag.interior ? {8'hFF, med[2], med[1], med[0]} : s1_center;
    out_last <= s1_tag.last;
  end

  assign s1_busy = s1_valid;
endmodule

[rtl/mf3_out_fifo.sv]
module mf3_out_fifo #(
  parameter int DEPTH = mf3_pkg::FIFO_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic [mf3_pkg::PIX_W-1:0]         push_pixel,
  input  logic                              push_last,
  output logic [$clog2(DEPTH+1)-1:0]        count,
  mf3_out_if.source                         out_ch
);
  import mf3_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [PIX_W:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic pop;

  assign pop = out_ch.valid & out_ch.ready;
  assign out_ch.valid = (count != '0);
  assign out_ch.pixel_out = mem[rd_ptr][PIX_W-1:0];
  assign out_ch.frame_last = mem[rd_ptr][PIX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + {{($bits(count)-1){1'b0}}, push} - {{($bits(count)-1){1'b0}}, pop};
    end
    if (push) begin
      mem[wr_ptr] <= {push_last, push_pixel};
    end
  end
endmodule

[rtl/median_filter_3x3_rgb.sv]
// Results pass registers pa, pb, s1, out and the output queue. Throughput: one
// request per cycle while in_ch.ready; each pixel touches both line memories once
// (read at accept, written next cycle, forwarded when the row is one pixel wide).
// Output is one row plus one pixel behind input; drain requests flush the tail.
// Reset (rst, synchronous): positions, window and queue clear; width 640, height 480.
// Line memories are not cleared; unwritten entries only reach border pixels.
module median_filter_3x3_rgb #(
  parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF
) (
  input logic       clk,
  input logic       rst,
  mf3_in_if.sink    in_ch,
  mf3_out_if.source out_ch,
  mf3_cfg_if.sink   cfg
);
  import mf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = WW + HW + 1;
  localparam int FCW = $clog2(FIFO_DEPTH + 1);

  logic [CFGW_W-1:0] image_width;
  logic [CFGH_W-1:0] image_height;
  logic [WW-1:0] w_act;
  logic [HW-1:0] h_act;
  logic [PW-1:0] total;

  logic [CW-1:0] in_col;
  logic [PW-1:0] in_cnt;
  logic [CW-1:0] out_col;
  logic [HW-1:0] out_row;
  logic [PW-1:0] out_cnt;

  logic in_acc, cfg_acc, go, restart;
  logic [PW-1:0] pin_e, pout_e;
  logic [CW-1:0] col_e, ocol_e;
  logic [HW-1:0] orow_e;
  logic emit, interior, last;
  logic [PIX_W-1:0] px_e;

  logic pa_valid, pa_emit, pa_fwd;
  mf3_tag_t pa_tag;
  logic [PIX_W-1:0] pa_px;
  logic [CW-1:0] pa_col;

  logic [PIX_W-1:0] rd_up, rd_lo, up_eff, lo_eff, wr_up, wr_lo;
  logic [TAPS-1:0][PIX_W-1:0] win;
  logic pb_valid;
  mf3_tag_t pb_tag;

  logic s1_busy, res_valid, res_last;
  logic [PIX_W-1:0] res_pixel;
  logic [FCW-1:0] fifo_cnt;
  logic [FCW:0] occupancy;

  always_comb begin
    if (image_width == '0) begin
      w_act = WW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_act = WW'(MAX_WIDTH);
    end else begin
      w_act = WW'(image_width);
    end
    if (image_height == '0) begin
      h_act = HW'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_act = HW'(MAX_HEIGHT);
    end else begin
      h_act = HW'(image_height);
    end
  end

  assign total = PW'(w_act) * PW'(h_act);

  assign occupancy = (FCW+1)'(fifo_cnt) + (FCW+1)'(pa_valid & pa_emit)
                   + (FCW+1)'(pb_valid) + (FCW+1)'(s1_busy) + (FCW+1)'(res_valid);
  assign in_ch.ready = (occupancy < (FCW+1)'(FIFO_DEPTH));
  assign cfg.ready = 1'b1;

  assign in_acc = in_ch.valid & in_ch.ready;
  assign cfg_acc = cfg.valid & cfg.ready;
  assign restart = (in_ch.op == OP_PIXEL) && (in_cnt >= total);
  assign go = in_acc && !((in_ch.op == OP_DRAIN) && (in_cnt < total));

  always_comb begin
    pin_e = restart ? '0 : in_cnt;
    pout_e = restart ? '0 : out_cnt;
    col_e = restart ? '0 : in_col;
    ocol_e = restart ? '0 : out_col;
    orow_e = restart ? '0 : out_row;
    px_e = (in_ch.op == OP_DRAIN) ? '0 : in_ch.pixel_in;
    emit = pin_e >= pout_e + PW'(w_act) + PW'(1);
    interior = (orow_e != '0) && ((HW+1)'(orow_e) + (HW+1)'(2) <= (HW+1)'(h_act))
            && (ocol_e != '0) && ((WW+1)'(ocol_e) + (WW+1)'(2) <= (WW+1)'(w_act));
    last = (pout_e == total - PW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      in_col <= '0;
      in_cnt <= '0;
      out_col <= '0;
      out_row <= '0;
      out_cnt <= '0;
      pa_valid <= 1'b0;
      pa_emit <= 1'b0;
    end else begin
      pa_valid <= go;
      pa_emit <= go & emit;
      if (cfg_acc) begin
        case (cfg_idx_t'(cfg.index))
          CFG_WIDTH: image_width <= cfg.data[CFGW_W-1:0];
          CFG_HEIGHT: image_height <= cfg.data[CFGH_W-1:0];
          default: ;
        endcase
        in_col <= '0;
        in_cnt <= '0;
        out_col <= '0;
        out_row <= '0;
        out_cnt <= '0;
      end else if (go) begin
        if (emit && last) begin
          in_col <= '0;
          in_cnt <= '0;
          out_col <= '0;
          out_row <= '0;
          out_cnt <= '0;
        end else begin
          in_cnt <= pin_e + PW'(1);
          in_col <= ((WW+1)'(col_e) + (WW+1)'(1) >= (WW+1)'(w_act)) ? '0 : col_e + 1'b1;
          if (emit) begin
            out_cnt <= pout_e + PW'(1);
            if ((WW+1)'(ocol_e) + (WW+1)'(1) >= (WW+1)'(w_act)) begin
              out_col <= '0;
              out_row <= orow_e + 1'b1;
            end else begin
              out_col <= ocol_e + 1'b1;
              out_row <= orow_e;
            end
          end else begin
            out_col <= ocol_e;
            out_row <= orow_e;
            out_cnt <= pout_e;
          end
        end
      end
    end
    pa_fwd <= pa_valid && (pa_col == col_e);
    pa_col <= col_e;
    pa_px <= px_e;
    pa_tag <= '{interior: interior, last: last};
  end

  mf3_line_mem #(.DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(pa_valid), .waddr(pa_col), .wdata(lo_eff),
    .re(go), .raddr(col_e), .rdata(rd_up)
  );

  mf3_line_mem #(.DEPTH(MAX_WIDTH)) u_lower (
    .clk(clk), .we(pa_valid), .waddr(pa_col), .wdata(pa_px),
    .re(go), .raddr(col_e), .rdata(rd_lo)
  );

  assign up_eff = pa_fwd ? wr_up : rd_up;
  assign lo_eff = pa_fwd ? wr_lo : rd_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
      pb_valid <= 1'b0;
    end else begin
      pb_valid <= pa_valid & pa_emit;
      if (pa_valid) begin
        for (int r = 0; r < 3; r++) begin
          win[r*3] <= win[r*3+1];
          win[r*3+1] <= win[r*3+2];
        end
        win[2] <= up_eff;
        win[5] <= lo_eff;
        win[8] <= pa_px;
      end
    end
    if (pa_valid) begin
      wr_up <= lo_eff;
      wr_lo <= pa_px;
    end
    pb_tag <= pa_tag;
  end

  mf3_median u_median (
    .clk(clk), .rst(rst), .in_valid(pb_valid), .in_tag(pb_tag), .win(win),
    .s1_busy(s1_busy), .out_valid(res_valid), .out_pixel(res_pixel), .out_last(res_last)
  );

  mf3_out_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst(rst), .push(res_valid), .push_pixel(res_pixel),
    .push_last(res_last), .count(fifo_cnt), .out_ch(out_ch)
  );
endmodule

[rtl/mf3_checker.sv]
`include "median_filter_3x3_rgb_assert.svh"

module mf3_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mf3_pkg::PIX_W-1:0]  pixel_out,
  input logic                       cfg_ready
);
  `MF3_ASSERT(a_ready_after_reset, rst |=> in_ready, "input not ready after reset")
  `MF3_ASSERT(a_empty_after_reset, rst |=> !out_valid, "result present after reset")
  `MF3_ASSERT(a_cfg_ready, cfg_ready, "config port stalled")
  `MF3_ASSERT_RST(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(pixel_out), "stalled result changed")
endmodule

bind median_filter_3x3_rgb mf3_checker u_mf3_checker (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .pixel_out(out_ch.pixel_out), .cfg_ready(cfg.ready)
);
